// ===== rtl/cptp_pkg.sv =====
`timescale 1ns / 1ps

package cptp_pkg;

  // card position register width; also the width of the column field
  localparam int POS_W = 7;
  localparam int PUNCH_W = 16;
  localparam int ROW_W = 4;
  localparam int KW_N = 3;
  localparam int OUT_DATA_W = 32;

  // line phase
  typedef enum logic [1:0] {
    PH_START,
    PH_KEYWORD,
    PH_DATA,
    PH_SKIP
  } phase_t;

  // result kinds
  localparam logic [1:0] RK_WORD  = 2'd0;
  localparam logic [1:0] RK_CARD  = 2'd1;
  localparam logic [1:0] RK_ERROR = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_STRAY_START = 3'd1;
  localparam logic [2:0] ERR_STRAY_END   = 3'd2;
  localparam logic [2:0] ERR_BAD_PUNCH   = 3'd3;
  localparam logic [2:0] ERR_BAD_CHAR    = 3'd4;
  localparam logic [2:0] ERR_KW_EXPECTED = 3'd5;

  // keyword indexes
  localparam logic [1:0] KW_START = 2'd0;
  localparam logic [1:0] KW_END   = 2'd1;
  localparam logic [1:0] KW_BLANK = 2'd2;

  // character codes
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_HYPHEN  = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_CASE    = 8'h20;

  // row number to punch mask bit; rows ten and above twelve have none
  function automatic logic [PUNCH_W-1:0] row_bit(input logic [ROW_W-1:0] row);
    logic [PUNCH_W-1:0] m;
    case (row)
      4'd0:    m = 16'h2000;
      4'd1:    m = 16'h1000;
      4'd2:    m = 16'h0800;
      4'd3:    m = 16'h0400;
      4'd4:    m = 16'h0200;
      4'd5:    m = 16'h0100;
      4'd6:    m = 16'h0080;
      4'd7:    m = 16'h0040;
      4'd8:    m = 16'h0020;
      4'd9:    m = 16'h0010;
      4'd11:   m = 16'h4000;
      4'd12:   m = 16'h8000;
      default: m = 16'h0000;
    endcase
    return m;
  endfunction

  // keyword lengths
  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] n;
    case (k)
      KW_START: n = 3'd5;
      KW_END:   n = 3'd3;
      KW_BLANK: n = 3'd5;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  // keyword text, lower case
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
    logic [7:0] c;
    case ({k, p})
      {KW_START, 3'd0}: c = 8'h73; // s
      {KW_START, 3'd1}: c = 8'h74; // t
      {KW_START, 3'd2}: c = 8'h61; // a
      {KW_START, 3'd3}: c = 8'h72; // r
      {KW_START, 3'd4}: c = 8'h74; // t
      {KW_END, 3'd0}:   c = 8'h65; // e
      {KW_END, 3'd1}:   c = 8'h6E; // n
      {KW_END, 3'd2}:   c = 8'h64; // d
      {KW_BLANK, 3'd0}: c = 8'h62; // b
      {KW_BLANK, 3'd1}: c = 8'h6C; // l
      {KW_BLANK, 3'd2}: c = 8'h61; // a
      {KW_BLANK, 3'd3}: c = 8'h6E; // n
      {KW_BLANK, 3'd4}: c = 8'h6B; // k
      default:          c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/card_punch_text_parser.sv =====
`timescale 1ns / 1ps

// channel  direction  tdata                                     tuser
// in_      input      [7:0] char_code                          [0] kind
// out_     output     [6:0] column, [22:7] punches,             [1:0] result_kind
//                     [25:23] error_code, [31:26] zero
//
// one input word is taken every cycle unless the output register is full and stalled;
// its result, if any, appears in the output register on the next cycle.
// the parser state and the output register are the only storage; a word is
// taken whenever the output register is empty or being drained.
// reset (synchronous, active low) clears all parser state and the output valid flag.
// after an error the block takes input words but gives no result until reset.

module card_punch_text_parser
  import cptp_pkg::*;
#(
  parameter int COLUMNS = 80
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] char_code
  input  logic [0:0]            in_tuser,   // [0] kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [6:0] column, [22:7] punches, [25:23] error_code
  output logic [1:0]            out_tuser   // [1:0] result_kind
);

  localparam logic [POS_W-1:0] COL_LAST = POS_W'(COLUMNS);
  localparam logic [POS_W-1:0] POS_END  = POS_W'(COLUMNS + 1);

  // parser state
  logic [POS_W-1:0]   pos_r, pos_nxt;
  phase_t             phase_r, phase_nxt;
  logic [2:0]         prog_r, prog_nxt;
  logic [KW_N-1:0]    cand_r, cand_nxt;
  logic [PUNCH_W-1:0] mask_r, mask_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               digit_r, digit_nxt;
  logic               space_r, space_nxt;
  logic               err_r, err_nxt;

  // output register
  logic                  out_vld_r, out_vld_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [1:0]            out_user_r, out_user_nxt;

  logic       in_fire;
  logic [7:0] ch;
  logic [7:0] lc;
  logic       is_start;
  logic       in_card;
  logic       is_comment;
  logic       is_digit;

  // values seen by the current word; a new line starts from cleared state
  logic [2:0]         eff_p;
  logic [KW_N-1:0]    eff_cand;
  logic [PUNCH_W-1:0] eff_mask;
  logic [ROW_W-1:0]   eff_row;
  logic               eff_digit;
  logic               eff_space;

  logic [KW_N-1:0]    new_cand;
  logic [KW_N-1:0]    kw_done;
  logic [3:0]         p_plus;
  logic [7:0]         acc_val;
  logic               row_ok;
  logic [PUNCH_W-1:0] mask_or;

  logic               do_kw;
  logic               do_data;
  logic               fin;
  logic               fail_en;
  logic [2:0]         fail_code;
  logic               emit;
  logic [1:0]         res_kind;
  logic [POS_W-1:0]   res_col;
  logic [PUNCH_W-1:0] res_punch;

  assign in_tready = !out_vld_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign ch        = in_tdata;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // character classes
  assign lc = (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ? (ch + CH_CASE) : ch;
  assign is_comment = (ch == CH_SEMI) || (ch == CH_HASH) || (ch == CH_STAR);
  assign is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign in_card    = (pos_r >= POS_W'(1)) && (pos_r <= COL_LAST);

  assign is_start  = (phase_r == PH_START);
  assign eff_p     = is_start ? 3'd0 : prog_r;
  assign eff_cand  = is_start ? {KW_N{1'b1}} : cand_r;
  assign eff_mask  = is_start ? '0 : mask_r;
  assign eff_row   = is_start ? '0 : row_r;
  assign eff_digit = is_start ? 1'b0 : digit_r;
  assign eff_space = is_start ? 1'b0 : space_r;

  // keyword matching, one lane per keyword
  assign p_plus = {1'b0, eff_p} + 4'd1;
  always_comb begin
    for (int k = 0; k < KW_N; k++) begin
      new_cand[k] = eff_cand[k] && (eff_p < kw_len(2'(k))) && (lc == kw_char(2'(k), eff_p));
      kw_done[k]  = new_cand[k] && (p_plus == {1'b0, kw_len(2'(k))});
    end
  end

  // row number arithmetic
  assign acc_val = {1'b0, eff_row, 3'b000} + {3'b000, eff_row, 1'b0} + {4'b0000, ch[3:0]};
  assign row_ok  = eff_digit && (eff_row <= 4'd12) && (eff_row != 4'd10);
  assign mask_or = eff_mask | row_bit(eff_row);

  // per-word parse step
  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    prog_nxt  = prog_r;
    cand_nxt  = cand_r;
    mask_nxt  = mask_r;
    row_nxt   = row_r;
    digit_nxt = digit_r;
    space_nxt = space_r;
    err_nxt   = err_r;
    do_kw     = 1'b0;
    do_data   = 1'b0;
    fin       = 1'b0;
    fail_en   = 1'b0;
    fail_code = ERR_NONE;
    emit      = 1'b0;
    res_kind  = RK_WORD;
    res_col   = '0;
    res_punch = '0;

    if (in_fire && !err_r) begin
      if (in_tuser[0] || ch == CH_NEWLINE) begin
        // line end
        phase_nxt = PH_START;
        if (phase_r == PH_KEYWORD) begin
          fail_en   = 1'b1;
          fail_code = in_card ? ERR_BAD_CHAR : ERR_KW_EXPECTED;
        end else if (phase_r == PH_DATA) begin
          fin = 1'b1;
        end
      end else begin
        case (phase_r)
          PH_START: begin
            if (ch <= CH_SPACE) begin
              phase_nxt = PH_START;
            end else if (is_comment) begin
              phase_nxt = PH_SKIP;
            end else begin
              phase_nxt = PH_KEYWORD;
              mask_nxt  = '0;
              row_nxt   = '0;
              digit_nxt = 1'b0;
              space_nxt = 1'b0;
              do_kw     = 1'b1;
            end
          end
          PH_KEYWORD: do_kw = 1'b1;
          PH_DATA:    do_data = 1'b1;
          default:    phase_nxt = phase_r;
        endcase

        // keyword step and action
        if (do_kw) begin
          cand_nxt = new_cand;
          prog_nxt = p_plus[2:0];
          if (kw_done[KW_START]) begin
            phase_nxt = PH_SKIP;
            if (pos_r == '0) begin
              pos_nxt = POS_W'(1);
            end else begin
              fail_en   = 1'b1;
              fail_code = ERR_STRAY_START;
            end
          end else if (kw_done[KW_END]) begin
            phase_nxt = PH_SKIP;
            if (pos_r == POS_END) begin
              pos_nxt  = '0;
              emit     = 1'b1;
              res_kind = RK_CARD;
            end else begin
              fail_en   = 1'b1;
              fail_code = ERR_STRAY_END;
            end
          end else if (kw_done[KW_BLANK]) begin
            phase_nxt = PH_SKIP;
            if (in_card) begin
              pos_nxt  = pos_r + POS_W'(1);
              emit     = 1'b1;
              res_kind = RK_WORD;
              res_col  = pos_r;
            end else begin
              fail_en   = 1'b1;
              fail_code = ERR_KW_EXPECTED;
            end
          end else if (new_cand != '0) begin
            phase_nxt = PH_KEYWORD;
          end else if (eff_p == 3'd0 && in_card) begin
            phase_nxt = PH_DATA;
            do_data   = 1'b1;
          end else begin
            fail_en   = 1'b1;
            fail_code = in_card ? ERR_BAD_CHAR : ERR_KW_EXPECTED;
          end
        end

        // data character
        if (do_data) begin
          if (is_digit) begin
            if (eff_space) begin
              fail_en   = 1'b1;
              fail_code = ERR_BAD_CHAR;
            end else begin
              row_nxt   = (acc_val > 8'd15) ? 4'd15 : acc_val[ROW_W-1:0];
              digit_nxt = 1'b1;
            end
          end else if (ch == CH_HYPHEN) begin
            if (eff_space) begin
              fail_en   = 1'b1;
              fail_code = ERR_BAD_CHAR;
            end else if (!row_ok) begin
              fail_en   = 1'b1;
              fail_code = ERR_BAD_PUNCH;
            end else begin
              mask_nxt  = mask_or;
              row_nxt   = '0;
              digit_nxt = 1'b0;
            end
          end else if (ch <= CH_SPACE) begin
            space_nxt = 1'b1;
          end else if (is_comment) begin
            phase_nxt = PH_SKIP;
            fin       = 1'b1;
          end else begin
            fail_en   = 1'b1;
            fail_code = ERR_BAD_CHAR;
          end
        end
      end

      // close a data line into a column word
      if (fin) begin
        if (!row_ok) begin
          fail_en   = 1'b1;
          fail_code = ERR_BAD_PUNCH;
        end else begin
          mask_nxt  = mask_or;
          pos_nxt   = pos_r + POS_W'(1);
          emit      = 1'b1;
          res_kind  = RK_WORD;
          res_col   = pos_r;
          res_punch = mask_or;
        end
      end

      // first error wins and silences the block
      if (fail_en) begin
        err_nxt   = 1'b1;
        emit      = 1'b1;
        res_kind  = RK_ERROR;
        res_col   = '0;
        res_punch = '0;
      end
    end
  end

  // output register load
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    if (in_tready) begin
      out_vld_nxt  = in_fire && emit;
      out_data_nxt = {{(OUT_DATA_W - POS_W - PUNCH_W - 3){1'b0}},
                      (fail_en ? fail_code : ERR_NONE), res_punch, res_col};
      out_user_nxt = res_kind;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      phase_r   <= PH_START;
      prog_r    <= '0;
      cand_r    <= {KW_N{1'b1}};
      mask_r    <= '0;
      row_r     <= '0;
      digit_r   <= 1'b0;
      space_r   <= 1'b0;
      err_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      prog_r    <= prog_nxt;
      cand_r    <= cand_nxt;
      mask_r    <= mask_nxt;
      row_r     <= row_nxt;
      digit_r   <= digit_nxt;
      space_r   <= space_nxt;
      err_r     <= err_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

// ===== tb/card_punch_text_parser_test.sv =====
`timescale 1ns / 1ps

import cptp_pkg::*;

localparam int CARD_COLUMNS = 80;
localparam bit KIND_TEXT = 1'b0;
localparam bit KIND_EOT = 1'b1;

// tracks the parser state and holds the column words, card ends and errors still due
class card_parse_checker;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  column;
    logic [15:0] punches;
    logic [2:0]  err;
  } card_result_t;

  card_result_t pending_words[$];
  int failures;

  int position;
  phase_t phase;
  int kw_pos;
  logic [2:0] kw_alive;
  logic [15:0] mask;
  int row;
  bit digit_seen;
  bit gap_seen;
  bit locked;
  string kw_word[3];

  function new();
    failures = 0;
    position = 0;
    phase = PH_START;
    kw_pos = 0;
    kw_alive = 3'b111;
    mask = '0;
    row = 0;
    digit_seen = 1'b0;
    gap_seen = 1'b0;
    locked = 1'b0;
    kw_word[KW_START] = "start";
    kw_word[KW_END] = "end";
    kw_word[KW_BLANK] = "blank";
  endfunction

  function logic [15:0] mask_for_row(int r);
    case (r)
      0: return 16'h2000;
      1: return 16'h1000;
      2: return 16'h0800;
      3: return 16'h0400;
      4: return 16'h0200;
      5: return 16'h0100;
      6: return 16'h0080;
      7: return 16'h0040;
      8: return 16'h0020;
      9: return 16'h0010;
      11: return 16'h4000;
      12: return 16'h8000;
      default: return 16'h0000;
    endcase
  endfunction

  function void push_result(logic [1:0] k, int col, logic [15:0] p, logic [2:0] e);
    card_result_t r;
    r.kind = k;
    r.column = 7'(col);
    r.punches = p;
    r.err = e;
    pending_words.push_back(r);
  endfunction

  // first error is reported, then everything is swallowed
  function void stop_on(logic [2:0] e);
    locked = 1'b1;
    push_result(RK_ERROR, 0, '0, e);
  endfunction

  function bit in_card();
    return position >= 1 && position <= CARD_COLUMNS;
  endfunction

  function bit row_valid();
    return digit_seen && row <= 12 && row != 10;
  endfunction

  function bit is_comment(logic [7:0] c);
    return c == CH_SEMI || c == CH_HASH || c == CH_STAR;
  endfunction

  function void close_column();
    if (!row_valid()) begin
      stop_on(ERR_BAD_PUNCH);
      return;
    end
    mask |= mask_for_row(row);
    push_result(RK_WORD, position, mask, ERR_NONE);
    position++;
  endfunction

  function void data_byte(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (gap_seen) begin
        stop_on(ERR_BAD_CHAR);
        return;
      end
      row = row * 10 + int'(c - CH_ZERO);
      if (row > 15) row = 15;
      digit_seen = 1'b1;
    end else if (c == CH_HYPHEN) begin
      if (gap_seen) stop_on(ERR_BAD_CHAR);
      else if (!row_valid()) stop_on(ERR_BAD_PUNCH);
      else begin
        mask |= mask_for_row(row);
        row = 0;
        digit_seen = 1'b0;
      end
    end else if (c <= CH_SPACE) begin
      gap_seen = 1'b1;
    end else if (is_comment(c)) begin
      phase = PH_SKIP;
      close_column();
    end else begin
      stop_on(ERR_BAD_CHAR);
    end
  endfunction

  function void keyword_hit(int k);
    phase = PH_SKIP;
    if (k == KW_START) begin
      if (position == 0) position = 1;
      else stop_on(ERR_STRAY_START);
    end else if (k == KW_END) begin
      if (position == CARD_COLUMNS + 1) begin
        position = 0;
        push_result(RK_CARD, 0, '0, ERR_NONE);
      end else begin
        stop_on(ERR_STRAY_END);
      end
    end else if (in_card()) begin
      push_result(RK_WORD, position, '0, ERR_NONE);
      position++;
    end else begin
      stop_on(ERR_KW_EXPECTED);
    end
  endfunction

  function void keyword_byte(logic [7:0] c);
    logic [7:0] lc;
    int p;
    lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CH_CASE : c;
    p = kw_pos;
    // drop every keyword that no longer matches the prefix
    for (int k = 0; k < 3; k++) begin
      if (kw_alive[k] && !(p < kw_word[k].len() && lc == 8'(kw_word[k][p])))
        kw_alive[k] = 1'b0;
    end
    kw_pos = (p + 1) & 7;
    for (int k = 0; k < 3; k++) begin
      if (kw_alive[k] && kw_word[k].len() == p + 1) begin
        keyword_hit(k);
        return;
      end
    end
    if (kw_alive != 3'b000) return;
    // a card line that opens with no keyword letter is row data
    if (p == 0 && in_card()) begin
      phase = PH_DATA;
      data_byte(c);
    end else begin
      stop_on(in_card() ? ERR_BAD_CHAR : ERR_KW_EXPECTED);
    end
  endfunction

  function void close_line();
    phase_t was;
    was = phase;
    phase = PH_START;
    if (was == PH_KEYWORD) stop_on(in_card() ? ERR_BAD_CHAR : ERR_KW_EXPECTED);
    else if (was == PH_DATA) close_column();
  endfunction

  // one accepted input word
  function void note_input(bit kind, logic [7:0] c);
    if (locked) return;
    if (kind == KIND_EOT || c == CH_NEWLINE) begin
      close_line();
      return;
    end
    case (phase)
      PH_START: begin
        if (c <= CH_SPACE) return;
        if (is_comment(c)) begin
          phase = PH_SKIP;
          return;
        end
        phase = PH_KEYWORD;
        kw_pos = 0;
        kw_alive = 3'b111;
        mask = '0;
        row = 0;
        digit_seen = 1'b0;
        gap_seen = 1'b0;
        keyword_byte(c);
      end
      PH_KEYWORD: keyword_byte(c);
      PH_DATA: data_byte(c);
      default: ;
    endcase
  endfunction

  // one accepted output word against the oldest one due
  function void check_result(logic [31:0] data, logic [1:0] user);
    card_result_t want;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected result kind %0d column %0d punches %04h error %0d",
               $time, user, data[6:0], data[22:7], data[25:23]);
      failures++;
      return;
    end
    want = pending_words.pop_front();
    if (user !== want.kind || data[6:0] !== want.column || data[22:7] !== want.punches ||
        data[25:23] !== want.err || data[31:26] !== 6'd0) begin
      $display({"%0t: expected kind %0d column %0d punches %04h error %0d pad 00, ",
                "got kind %0d column %0d punches %04h error %0d pad %02h"},
               $time, want.kind, want.column, want.punches, want.err,
               user, data[6:0], data[22:7], data[25:23], data[31:26]);
      failures++;
    end
  endfunction

endclass

module card_punch_text_parser_test;

  localparam int RANDOM_WORDS = 1250;
  localparam int PHASE_WORDS = 390;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] char_code
  logic [0:0]  in_tuser;   // [0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [6:0] column, [22:7] punches, [25:23] error_code
  logic [1:0]  out_tuser;  // [1:0] result_kind

  card_parse_checker parse_check = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_sent = 0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  bit pause_done = 1'b0;

  card_punch_text_parser #(
    .COLUMNS(CARD_COLUMNS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result checking and watchdog, sampled mid-cycle
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if (rst_n) begin
        if (out_tvalid && out_tready) parse_check.check_result(out_tdata, out_tuser);
        if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
        else quiet++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  // offer one word and wait for it to be taken
  task automatic send_word(input bit kind, input logic [7:0] code);
    bit taken;
    // idling pattern changes every few hundred words
    case ((words_sent / PHASE_WORDS) % 4)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 65; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 65; end
      default: begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= code;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end
    parse_check.note_input(kind, code);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(KIND_TEXT, s[i]);
  endtask

  // newline, or now and then an end of text marker
  task automatic end_line();
    if ($urandom_range(7) == 0) send_word(KIND_EOT, 8'($urandom_range(255)));
    else send_word(KIND_TEXT, CH_NEWLINE);
  endtask

  task automatic send_blanks(input int n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom_range(32));
      if (c == CH_NEWLINE) c = CH_SPACE;
      send_word(KIND_TEXT, c);
    end
  endtask

  // any byte but a newline
  task automatic send_junk(input int n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom_range(255));
      if (c == CH_NEWLINE) c = 8'hFF;
      send_word(KIND_TEXT, c);
    end
  endtask

  function automatic logic [7:0] comment_char();
    case ($urandom_range(2))
      0: return CH_SEMI;
      1: return CH_HASH;
      default: return CH_STAR;
    endcase
  endfunction

  // keyword in random case with an optional tail
  task automatic send_keyword(input string kw);
    logic [7:0] c;
    send_blanks(($urandom_range(3) == 0) ? 1 : 0);
    for (int i = 0; i < kw.len(); i++) begin
      c = kw[i];
      if ($urandom_range(1)) c = c - CH_CASE;
      send_word(KIND_TEXT, c);
    end
    if ($urandom_range(2) == 0) send_junk($urandom_range(1, 6));
    end_line();
  endtask

  // empty, blank-only or comment line
  task automatic send_filler_line();
    case ($urandom_range(3))
      0: end_line();
      1: begin
        send_blanks($urandom_range(1, 3));
        end_line();
      end
      2: begin
        send_blanks($urandom_range(2));
        send_word(KIND_TEXT, comment_char());
        send_junk($urandom_range(8));
        end_line();
      end
      default: send_word(KIND_EOT, 8'($urandom_range(255)));
    endcase
  endtask

  // one well-formed card column
  task automatic send_data_line();
    int rows;
    int v;
    send_blanks(($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
    if ($urandom_range(9) == 0) begin
      send_keyword("blank");
      return;
    end
    rows = ($urandom_range(15) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
    for (int r = 0; r < rows; r++) begin
      if (r > 0) send_word(KIND_TEXT, CH_HYPHEN);
      v = $urandom_range(11);
      if (v == 10) v = 12;
      if ($urandom_range(15) == 0) send_word(KIND_TEXT, CH_ZERO);
      if (v >= 10) begin
        send_word(KIND_TEXT, CH_ZERO + 8'd1);
        send_word(KIND_TEXT, CH_ZERO + 8'(v - 10));
      end else begin
        send_word(KIND_TEXT, CH_ZERO + 8'(v));
      end
    end
    case ($urandom_range(5))
      0: send_blanks($urandom_range(1, 3));
      1: begin
        send_blanks($urandom_range(2));
        send_word(KIND_TEXT, comment_char());
        send_junk($urandom_range(6));
      end
      default: ;
    endcase
    end_line();
  endtask

  task automatic send_data_lines(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0) send_filler_line();
      send_data_line();
      // long receiver hold-off while words keep coming
      if (!hold_done && words_sent >= 600) begin
        hold_request = 1'b1;
        hold_done = 1'b1;
      end
      // sender waits for every result to drain
      if (!pause_done && words_sent >= 1000) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (parse_check.pending_words.size() != 0);
        pause_done = 1'b1;
      end
    end
  endtask

  task automatic send_card();
    repeat ($urandom_range(2)) send_filler_line();
    send_keyword("start");
    send_data_lines(CARD_COLUMNS);
    if ($urandom_range(3) == 0) send_filler_line();
    send_keyword("end");
  endtask

  // stimulus
  initial begin
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // blank, empty and comment lines before any card
    send_word(KIND_EOT, 8'h00);
    send_word(KIND_TEXT, CH_NEWLINE);
    send_word(KIND_TEXT, 8'h00);
    send_word(KIND_TEXT, CH_SPACE);
    send_word(KIND_TEXT, 8'h1F);
    send_word(KIND_TEXT, CH_NEWLINE);
    send_text(";");
    send_word(KIND_TEXT, 8'hFF);
    send_word(KIND_TEXT, 8'h80);
    send_word(KIND_TEXT, CH_NEWLINE);

    // first card: every row, leading zeros, comments, keyword tails, end of text
    send_text("  StArTing deck\n");
    send_text("12-11-0-1-2-3-4-5-6-7-8-9\n");
    send_text("0\n");
    send_text("012 ;twelve\n");
    send_text("011#");
    send_word(KIND_TEXT, 8'hFF);
    send_word(KIND_TEXT, CH_NEWLINE);
    send_text("BLANKet\n");
    send_text("9\t");
    send_word(KIND_EOT, 8'hFF);
    send_text("3-3*x\n");
    send_text("  blank");
    send_word(KIND_EOT, 8'h5A);
    send_data_lines(CARD_COLUMNS - 8);
    send_text("End of first card\n");

    // random decks
    while (words_sent < RANDOM_WORDS) send_card();

    // one fatal case to close the run
    case ($urandom_range(14))
      0: send_text("start\nstart\n");            // start inside a card
      1: send_text("end\n");                     // end outside a card
      2: send_text("start\n10\n");               // row ten
      3: send_text("start\n13-1\n");             // row above twelve
      4: send_text("start\n5-\n");               // trailing hyphen
      5: send_text("start\n-\n");                // missing number
      6: send_text("start\n1 2\n");              // inner space before digit
      7: send_text("start\n 3 -4\n");            // inner space before hyphen
      8: begin                                   // high byte opening a card line
        send_text("start\n");
        send_word(KIND_TEXT, 8'($urandom_range(8'h80, 8'hFF)));
        end_line();
      end
      9: send_text("start\nbla\n");              // keyword cut short in a card
      10: send_text("start\n7x\n");              // bad byte in row data
      11: send_text("12\n");                     // data outside a card
      12: send_text("blank\n");                  // blank outside a card
      13: send_text("ent\n");                    // keyword mismatch outside a card
      default: begin                             // high byte outside a card
        send_word(KIND_TEXT, 8'($urandom_range(8'h80, 8'hFF)));
        end_line();
      end
    endcase

    // the block must stay silent from here on
    repeat (40) send_word(1'($urandom_range(1)), 8'($urandom_range(255)));

    in_tvalid <= 1'b0;
    do @(posedge clk); while (parse_check.pending_words.size() != 0);
    repeat (4) @(posedge clk);
    if (parse_check.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== card_punch_text_parser.f =====
rtl/cptp_pkg.sv
rtl/card_punch_text_parser.sv
tb/card_punch_text_parser_test.sv
